// ===== rtl/txts_pkg.sv =====
// txts_pkg: shared types and constants of the transmit timestamp history ring.
// Used by txts_ctl, txts_dp and the top level; depends on nothing else.
package txts_pkg;

  localparam int SEQ_W       = 16;
  localparam int STAMP_W     = 40;
  localparam int CNT_W       = 5;
  localparam int ENTRY_W     = STAMP_W + SEQ_W;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_LATEST = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_F_SCAN,
    ST_F_DRAIN,
    ST_F_EMIT,
    ST_L_RD,
    ST_L_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture the input transaction
    logic push;        // advance index, write pair
    logic clear;       // drop all entries, index to zero
    logic scan_start;  // reset scan position and hit
    logic scan_step;   // read next entry in search order
    logic lat_start;   // newest-first pointer to write index
    logic lat_read;    // read entry at newest-first pointer
    logic lat_emit;    // load result from read entry, step pointer
    logic emit_find;   // load result from search hit
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_t kind;
    logic  n_zero;     // latest-n count is zero
    logic  rem_last;   // one latest-n result left
    logic  scan_last;  // this step reads the final entry
    logic  out_free;   // output register can take a result
  } sts_t;

endpackage

// ===== rtl/tx_timestamp_history_ring_top.sv =====
// tx_timestamp_history_ring_top: ring of transmitted (timestamp, sequence) pairs
// with sequence search and newest-first readout. Uses txts_pkg, txts_ctl, txts_dp.
//
// Usage:
//   Input channel (in_*): one transaction per command. in_tuser selects the kind:
//   push pair, clear store, find by sequence, read latest n. Push and clear give
//   no result. Find gives exactly one result (tlast set). Latest-n gives up to
//   min(DEPTH,16) results, newest first, tlast on the final one; a count of zero
//   gives none.
//   Output channel (out_*): tdata holds the stamp and sequence of the entry,
//   tuser[0] is the found flag (stamp nonzero).
// Timing (one command in flight at a time; the FSM walks the memory read port):
//   push / clear : accept, decode with the write or clear, then back to idle.
//   find         : decode, then one entry read per cycle through the single
//                  registered read port, search order fixed by the write index, then emit.
//   latest-n     : decode, then per result a read and a load of the output register.
// Reset (synchronous, rst_n low) empties the ring at once through per-entry valid
// bits, zeroes the write index and drops any pending result; no clearing pass.
// Backpressure: a result sits in the output register until out_tready; the block
// keeps accepting commands, and a later result waits until the register frees.
module tx_timestamp_history_ring_top import txts_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [15:0] seq_number, [55:16] stamp, [60:56] count
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [39:0] out_stamp, [55:40] out_seq
  output logic [0:0]  out_tuser,  // [0] found
  output logic        out_tlast
);

  cmd_t               cmd;
  sts_t               sts;
  logic [STAMP_W-1:0] res_stamp;
  logic [SEQ_W-1:0]   res_seq;
  logic               res_found;

  txts_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  txts_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (in_tuser),
    .in_seq     (in_tdata[15:0]),
    .in_stamp   (in_tdata[55:16]),
    .in_count   (in_tdata[60:56]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_stamp  (res_stamp),
    .out_seq    (res_seq),
    .out_found  (res_found),
    .out_last   (out_tlast)
  );

  assign out_tdata    = {res_seq, res_stamp};
  assign out_tuser[0] = res_found;

endmodule

// ===== rtl/txts_ctl.sv =====
// txts_ctl: sequencing state machine for push, clear, find and latest-n.
// Depends on txts_pkg; drives cmd_t into txts_dp and reads sts_t back.
module txts_ctl import txts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.kind)
          KIND_FIND:   state_nxt = ST_F_SCAN;
          KIND_LATEST: state_nxt = sts.n_zero ? ST_IDLE : ST_L_RD;
          default:     state_nxt = ST_IDLE;
        endcase
      end
      ST_F_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_F_DRAIN;
        end
      end
      ST_F_DRAIN: state_nxt = ST_F_EMIT;
      ST_F_EMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_L_RD: state_nxt = ST_L_EMIT;
      ST_L_EMIT: begin
        if (sts.out_free) begin
          state_nxt = sts.rem_last ? ST_IDLE : ST_L_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_DECODE: begin
        case (sts.kind)
          KIND_PUSH:   cmd.push       = 1'b1;
          KIND_CLEAR:  cmd.clear      = 1'b1;
          KIND_FIND:   cmd.scan_start = 1'b1;
          KIND_LATEST: cmd.lat_start  = 1'b1;
          default:     cmd.push       = 1'b0;
        endcase
      end
      ST_F_SCAN:  cmd.scan_step = 1'b1;
      ST_F_DRAIN: cmd.scan_step = 1'b0;
      ST_F_EMIT:  cmd.emit_find = sts.out_free;
      ST_L_RD:    cmd.lat_read  = 1'b1;
      ST_L_EMIT:  cmd.lat_emit  = sts.out_free;
      default:    cmd           = '0;
    endcase
  end

endmodule

// ===== rtl/txts_dp.sv =====
// txts_dp: history memory, entry valid bits, write index, search and output register.
// Depends on txts_pkg; commanded by txts_ctl.
module txts_dp import txts_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_kind,
  input  logic [SEQ_W-1:0]   in_seq,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic [CNT_W-1:0]   in_count,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [STAMP_W-1:0] out_stamp,
  output logic [SEQ_W-1:0]   out_seq,
  output logic               out_found,
  output logic               out_last
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIMIT = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(LIMIT);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic [AW-1:0]      wi_r;

  kind_t              kind_r;
  logic [SEQ_W-1:0]   key_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [CNT_W-1:0]   n_r;

  logic [AW-1:0]      p_r;
  logic [AW-1:0]      la_r;
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_ok_r;
  logic               rd_dn_r;
  logic               srch_v_r;

  logic [STAMP_W-1:0] hit_stamp_r;
  logic [SEQ_W-1:0]   hit_seq_r;
  logic               dn_found_r;
  logic               up_found_r;

  logic               out_v_r;
  logic [STAMP_W-1:0] out_stamp_r;
  logic [SEQ_W-1:0]   out_seq_r;
  logic               out_found_r;
  logic               out_last_r;

  logic [AW-1:0]      wi_inc;
  logic               scan_dn;
  logic [AW-1:0]      scan_addr;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic [STAMP_W-1:0] e_stamp;
  logic [SEQ_W-1:0]   e_seq;
  logic               out_free;
  logic [CNT_W-1:0]   n_sat;

  assign wi_inc    = (wi_r == LAST_ADDR) ? '0 : wi_r + 1'b1;
  // search order: index down to 0, then index+1 up to the end
  assign scan_dn   = (p_r <= wi_r);
  assign scan_addr = scan_dn ? (wi_r - p_r) : p_r;
  assign rd_addr   = cmd.scan_step ? scan_addr : la_r;
  assign rd_en     = cmd.scan_step | cmd.lat_read;
  // never-written entries read as zero
  assign e_stamp   = rd_ok_r ? rd_data_r[ENTRY_W-1:SEQ_W] : '0;
  assign e_seq     = rd_ok_r ? rd_data_r[SEQ_W-1:0] : '0;
  assign out_free  = !out_v_r || out_tready;
  assign n_sat     = (in_count > LIMIT_CNT) ? LIMIT_CNT : in_count;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wi_inc] <= {stamp_r, key_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_ok_r   <= vld_r[rd_addr];
      rd_dn_r   <= scan_dn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      wi_r     <= '0;
      srch_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        vld_r <= '0;
        wi_r  <= '0;
      end else if (cmd.push) begin
        vld_r[wi_inc] <= 1'b1;
        wi_r          <= wi_inc;
      end
      srch_v_r <= cmd.scan_step;
      if (cmd.emit_find || cmd.lat_emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind_t'(in_kind);
      key_r   <= in_seq;
      stamp_r <= in_stamp;
      n_r     <= n_sat;
    end else if (cmd.lat_emit) begin
      n_r <= n_r - 1'b1;
    end

    if (cmd.scan_start) begin
      p_r <= '0;
    end else if (cmd.scan_step) begin
      p_r <= p_r + 1'b1;
    end

    if (cmd.lat_start) begin
      la_r <= wi_r;
    end else if (cmd.lat_emit) begin
      la_r <= (la_r == '0) ? LAST_ADDR : la_r - 1'b1;
    end

    // down pass keeps its first match; up pass replaces it only when
    // the held hit has a zero stamp
    if (cmd.scan_start) begin
      hit_stamp_r <= '0;
      hit_seq_r   <= '0;
      dn_found_r  <= 1'b0;
      up_found_r  <= 1'b0;
    end else if (srch_v_r && e_seq == key_r) begin
      if (rd_dn_r) begin
        if (!dn_found_r) begin
          hit_stamp_r <= e_stamp;
          hit_seq_r   <= e_seq;
          dn_found_r  <= 1'b1;
        end
      end else if (!up_found_r && hit_stamp_r == '0) begin
        hit_stamp_r <= e_stamp;
        hit_seq_r   <= e_seq;
        up_found_r  <= 1'b1;
      end
    end

    if (cmd.emit_find) begin
      out_stamp_r <= hit_stamp_r;
      out_seq_r   <= hit_seq_r;
      out_found_r <= (hit_stamp_r != '0);
      out_last_r  <= 1'b1;
    end else if (cmd.lat_emit) begin
      out_stamp_r <= e_stamp;
      out_seq_r   <= e_seq;
      out_found_r <= (e_stamp != '0);
      out_last_r  <= (n_r == CNT_W'(1));
    end
  end

  always_comb begin
    sts.kind      = kind_r;
    sts.n_zero    = (n_r == '0);
    sts.rem_last  = (n_r == CNT_W'(1));
    sts.scan_last = (p_r == LAST_ADDR);
    sts.out_free  = out_free;
  end

  assign out_tvalid = out_v_r;
  assign out_stamp  = out_stamp_r;
  assign out_seq    = out_seq_r;
  assign out_found  = out_found_r;
  assign out_last   = out_last_r;

endmodule

// ===== rtl/txts_chk.sv =====
// txts_chk: port-level checks of the history ring, bound to the top level.
// Depends only on the top-level ports.
module txts_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // found flag tracks a nonzero stamp
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tdata[39:0] != 40'd0)))
    else $error("found flag disagrees with stamp");

  // reset drops any pending result
  a_rst_flush: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // one command in flight: no accept in the cycle after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("back-to-back command accept");

endmodule

bind tx_timestamp_history_ring_top txts_chk u_txts_chk (.*);
